@@ rtl/cgrp_pkg.sv @@
// Types and constants shared by the composite glyph record parser.
// Holds the request and response word types, parser phases and flag bits.
// No dependencies.
package cgrp_pkg;

   localparam int unsigned FlagWords = 0;
   localparam int unsigned FlagScale = 3;
   localparam int unsigned FlagMore  = 5;
   localparam int unsigned FlagXy    = 6;
   localparam int unsigned Flag2x2   = 7;
   localparam int unsigned FlagInstr = 8;

   localparam logic signed [15:0] F2d14One = 16'sd16384;

   typedef enum logic [3:0] {
      PH_FLAGS_HI = 4'd0,
      PH_FLAGS_LO = 4'd1,
      PH_IDX_HI   = 4'd2,
      PH_IDX_LO   = 4'd3,
      PH_ARGS     = 4'd4,
      PH_XFORM    = 4'd5,
      PH_LEN_HI   = 4'd6,
      PH_LEN_LO   = 4'd7,
      PH_INSTR    = 4'd8,
      PH_DONE     = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      KIND_COMPONENT = 2'd0,
      KIND_LENGTH    = 2'd1,
      KIND_INSTR     = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_word_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        comp_flags;
      logic [15:0]        child_glyph;
      logic signed [15:0] arg_one;
      logic signed [15:0] arg_two;
      logic signed [15:0] scale_xx;
      logic signed [15:0] scale_xy;
      logic signed [15:0] scale_yx;
      logic signed [15:0] scale_yy;
      logic [15:0]        instr_length;
      logic [7:0]         instr_byte;
      logic               last;
   } rsp_word_type;

   // transform byte count selected by the flag word, by priority
   function automatic logic [3:0] xform_bytes(input logic [15:0] flags);
      logic [3:0] n;
      if (flags[FlagScale]) begin
         n = 4'd2;
      end else if (flags[FlagXy]) begin
         n = 4'd4;
      end else if (flags[Flag2x2]) begin
         n = 4'd8;
      end else begin
         n = 4'd0;
      end
      return n;
   endfunction

endpackage

@@ rtl/composite_glyph_record_parser.sv @@
// Composite glyph record parser: top level.
// Depends on cgrp_pkg for word types, phases and flag constants.
//
// Usage:
//   req channel: one big-endian byte of a composite glyph description per word,
//   with start_req set on the first byte of a new glyph (optional right after
//   reset). A start_req mid-glyph abandons the glyph in progress.
//   rsp channel: component records (kind 0), then, if the instruction flag is
//   set, the instruction length (kind 1) and each instruction byte (kind 2).
//   last marks the final result of a glyph; bytes after it without start_req
//   are dropped.
// Throughput: one byte per cycle while req_stall is low. A result is held in the
//   output register, or in the skid register while rsp stalls, before it leaves.
// Stall: results go to an output register backed by one skid register; input
//   keeps flowing while a result waits, and req_stall rises only once the skid
//   register is occupied. req_stall is a register output.
// Reset: synchronous; the parser expects a flags high byte and both result
//   registers are emptied.
module composite_glyph_record_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cgrp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cgrp_pkg::rsp_word_type rsp_word
);
   import cgrp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [2:0]         byte_count_ff, byte_count_in;
   logic [7:0]         held_byte_ff, held_byte_in;
   logic [15:0]        cur_flags_ff, cur_flags_in;
   logic [15:0]        cur_index_ff, cur_index_in;
   logic signed [15:0] cur_args_ff [2];
   logic signed [15:0] cur_args_in [2];
   logic signed [15:0] cur_matrix_ff [4];
   logic signed [15:0] cur_matrix_in [4];
   logic [15:0]        instr_left_ff, instr_left_in;

   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_word_ff, out_word_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_word_type       skid_word_ff, skid_word_in;

   logic               req_acc;
   logic               res_valid;
   rsp_word_type       res_word;
   logic               emit_comp;
   phase_type          phase_eff;
   logic [7:0]         b;
   logic [2:0]         k;
   logic [15:0]        word_val;
   logic [3:0]         xbytes;
   logic [3:0]         k_next;

   assign req_acc   = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      held_byte_in  = held_byte_ff;
      cur_flags_in  = cur_flags_ff;
      cur_index_in  = cur_index_ff;
      cur_args_in   = cur_args_ff;
      cur_matrix_in = cur_matrix_ff;
      instr_left_in = instr_left_ff;
      res_valid     = 1'b0;
      res_word      = '0;
      emit_comp     = 1'b0;
      b             = req_word.data_byte;
      k             = byte_count_ff;
      word_val      = {held_byte_ff, b};
      xbytes        = xform_bytes(cur_flags_ff);
      k_next        = {1'b0, k} + 4'd1;
      phase_eff     = req_word.start_req ? PH_FLAGS_HI : phase_ff;

      case (phase_eff)
         PH_FLAGS_HI: begin
            cur_matrix_in[0] = F2d14One;
            cur_matrix_in[1] = '0;
            cur_matrix_in[2] = '0;
            cur_matrix_in[3] = F2d14One;
            cur_args_in[0]   = '0;
            cur_args_in[1]   = '0;
            held_byte_in     = b;
            phase_in         = PH_FLAGS_LO;
         end
         PH_FLAGS_LO: begin
            cur_flags_in = word_val;
            phase_in     = PH_IDX_HI;
         end
         PH_IDX_HI: begin
            held_byte_in = b;
            phase_in     = PH_IDX_LO;
         end
         PH_IDX_LO: begin
            cur_index_in  = word_val;
            byte_count_in = '0;
            phase_in      = PH_ARGS;
         end
         PH_ARGS: begin
            if (cur_flags_ff[FlagWords]) begin
               if (!k[0]) begin
                  held_byte_in = b;
               end else begin
                  cur_args_in[k[1]] = word_val;
               end
            end else begin
               cur_args_in[k[0]] = {{8{b[7]}}, b};
            end
            if ((cur_flags_ff[FlagWords] && k < 3'd3) ||
                (!cur_flags_ff[FlagWords] && k < 3'd1)) begin
               byte_count_in = k_next[2:0];
            end else begin
               byte_count_in = '0;
               if (xbytes == 4'd0) begin
                  emit_comp = 1'b1;
               end else begin
                  phase_in = PH_XFORM;
               end
            end
         end
         PH_XFORM: begin
            if (!k[0]) begin
               held_byte_in = b;
            end else if (cur_flags_ff[FlagScale]) begin
               cur_matrix_in[0] = word_val;
               cur_matrix_in[3] = word_val;
            end else if (cur_flags_ff[FlagXy]) begin
               cur_matrix_in[(k[2:1] != 2'd0) ? 2'd3 : 2'd0] = word_val;
            end else begin
               cur_matrix_in[k[2:1]] = word_val;
            end
            if (k_next < xbytes) begin
               byte_count_in = k_next[2:0];
            end else begin
               byte_count_in = '0;
               emit_comp     = 1'b1;
            end
         end
         PH_LEN_HI: begin
            held_byte_in = b;
            phase_in     = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            instr_left_in         = word_val;
            res_valid             = 1'b1;
            res_word.kind         = KIND_LENGTH;
            res_word.instr_length = word_val;
            if (word_val == 16'd0) begin
               phase_in      = PH_DONE;
               res_word.last = 1'b1;
            end else begin
               phase_in = PH_INSTR;
            end
         end
         PH_INSTR: begin
            instr_left_in       = instr_left_ff - 16'd1;
            res_valid           = 1'b1;
            res_word.kind       = KIND_INSTR;
            res_word.instr_byte = b;
            if (instr_left_in == 16'd0) begin
               phase_in      = PH_DONE;
               res_word.last = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (emit_comp) begin
         res_valid            = 1'b1;
         res_word.kind        = KIND_COMPONENT;
         res_word.comp_flags  = cur_flags_ff;
         res_word.child_glyph = cur_index_ff;
         res_word.arg_one     = cur_args_in[0];
         res_word.arg_two     = cur_args_in[1];
         res_word.scale_xx    = cur_matrix_in[0];
         res_word.scale_xy    = cur_matrix_in[1];
         res_word.scale_yx    = cur_matrix_in[2];
         res_word.scale_yy    = cur_matrix_in[3];
         if (cur_flags_ff[FlagMore]) begin
            phase_in = PH_FLAGS_HI;
         end else if (cur_flags_ff[FlagInstr]) begin
            phase_in = PH_LEN_HI;
         end else begin
            phase_in      = PH_DONE;
            res_word.last = 1'b1;
         end
      end
   end

   // output register and skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = req_acc && res_valid;
            skid_word_in  = res_word;
         end else begin
            out_valid_in = req_acc && res_valid;
            out_word_in  = res_word;
         end
      end else if (req_acc && res_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_FLAGS_HI;
         byte_count_ff    <= '0;
         held_byte_ff     <= '0;
         cur_flags_ff     <= '0;
         cur_index_ff     <= '0;
         cur_args_ff[0]   <= '0;
         cur_args_ff[1]   <= '0;
         cur_matrix_ff[0] <= F2d14One;
         cur_matrix_ff[1] <= '0;
         cur_matrix_ff[2] <= '0;
         cur_matrix_ff[3] <= F2d14One;
         instr_left_ff    <= '0;
      end else if (req_acc) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         held_byte_ff  <= held_byte_in;
         cur_flags_ff  <= cur_flags_in;
         cur_index_ff  <= cur_index_in;
         cur_args_ff   <= cur_args_in;
         cur_matrix_ff <= cur_matrix_in;
         instr_left_ff <= instr_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

@@ bench/tb.sv @@
// Testbench for composite_glyph_record_parser: directed glyph bytes, then random glyphs.
// Results are checked against a byte-level parser model kept in this file.
// Depends on cgrp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb;
   import cgrp_pkg::*;

   localparam int StallLimit = 5000;
   localparam int GlyphItems = 1200;
   localparam int HoldCycles = 300;

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type want;
   } glyph_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   composite_glyph_record_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // parser model state
   phase_type   glyph_phase;
   int          glyph_cnt;
   logic [7:0]  glyph_held;
   logic [15:0] glyph_flags;
   logic [15:0] glyph_child;
   logic [15:0] glyph_args [2];
   logic [15:0] glyph_mat [4];
   logic [15:0] glyph_left;

   rsp_word_type  records_due [$];
   glyph_row_type directed_rows [$];

   bit           offer_typed;
   rsp_word_type offer_want;
   bit           no_idle;
   bit           hold_receiver;
   bit           due_hit;
   rsp_word_type due_word;

   int errors;
   int quiet_cycles;
   int glyph_items;
   int glyphs_sent;
   int bytes_taken;
   int results_seen;
   int comp_seen;
   int length_seen;
   int instr_seen;

   function automatic int xform_len(input logic [15:0] f);
      if (f[FlagScale]) return 2;
      if (f[FlagXy]) return 4;
      if (f[Flag2x2]) return 8;
      return 0;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic clear_glyph_parser();
      glyph_phase = PH_FLAGS_HI;
      glyph_cnt = 0;
      glyph_held = 8'h00;
      glyph_flags = 16'h0000;
      glyph_child = 16'h0000;
      glyph_args[0] = 16'h0000;
      glyph_args[1] = 16'h0000;
      glyph_mat[0] = F2d14One;
      glyph_mat[1] = 16'h0000;
      glyph_mat[2] = 16'h0000;
      glyph_mat[3] = F2d14One;
      glyph_left = 16'h0000;
   endtask

   task automatic finish_component(output rsp_word_type r);
      r = '0;
      r.kind = KIND_COMPONENT;
      r.comp_flags = glyph_flags;
      r.child_glyph = glyph_child;
      r.arg_one = glyph_args[0];
      r.arg_two = glyph_args[1];
      r.scale_xx = glyph_mat[0];
      r.scale_xy = glyph_mat[1];
      r.scale_yx = glyph_mat[2];
      r.scale_yy = glyph_mat[3];
      if (glyph_flags[FlagMore]) begin
         glyph_phase = PH_FLAGS_HI;
      end else if (glyph_flags[FlagInstr]) begin
         glyph_phase = PH_LEN_HI;
      end else begin
         glyph_phase = PH_DONE;
         r.last = 1'b1;
      end
   endtask

   task automatic parse_glyph_byte(input req_word_type w, output bit hit,
                                   output rsp_word_type r);
      logic [7:0]  b;
      logic [15:0] wd;
      int          k;
      bit          args_done;
      b = w.data_byte;
      hit = 1'b0;
      r = '0;
      args_done = 1'b0;
      if (w.start_req) clear_glyph_parser();
      case (glyph_phase)
         PH_FLAGS_HI: begin
            glyph_mat[0] = F2d14One;
            glyph_mat[1] = 16'h0000;
            glyph_mat[2] = 16'h0000;
            glyph_mat[3] = F2d14One;
            glyph_args[0] = 16'h0000;
            glyph_args[1] = 16'h0000;
            glyph_held = b;
            glyph_phase = PH_FLAGS_LO;
         end
         PH_FLAGS_LO: begin
            glyph_flags = {glyph_held, b};
            glyph_phase = PH_IDX_HI;
         end
         PH_IDX_HI: begin
            glyph_held = b;
            glyph_phase = PH_IDX_LO;
         end
         PH_IDX_LO: begin
            glyph_child = {glyph_held, b};
            glyph_phase = PH_ARGS;
            glyph_cnt = 0;
         end
         PH_ARGS: begin
            k = glyph_cnt;
            if (glyph_flags[FlagWords]) begin
               if ((k & 1) == 0) glyph_held = b;
               else glyph_args[(k >> 1) & 1] = {glyph_held, b};
               if (k < 3) glyph_cnt = k + 1;
               else args_done = 1'b1;
            end else begin
               glyph_args[k & 1] = {{8{b[7]}}, b};
               if (k < 1) glyph_cnt = k + 1;
               else args_done = 1'b1;
            end
            if (args_done) begin
               glyph_cnt = 0;
               if (xform_len(glyph_flags) == 0) begin
                  finish_component(r);
                  hit = 1'b1;
               end else begin
                  glyph_phase = PH_XFORM;
               end
            end
         end
         PH_XFORM: begin
            k = glyph_cnt;
            if ((k & 1) == 0) begin
               glyph_held = b;
            end else begin
               wd = {glyph_held, b};
               if (glyph_flags[FlagScale]) begin
                  glyph_mat[0] = wd;
                  glyph_mat[3] = wd;
               end else if (glyph_flags[FlagXy]) begin
                  glyph_mat[(k >> 1) != 0 ? 3 : 0] = wd;
               end else begin
                  glyph_mat[(k >> 1) & 3] = wd;
               end
            end
            if (k + 1 < xform_len(glyph_flags)) begin
               glyph_cnt = (k + 1) & 7;
            end else begin
               glyph_cnt = 0;
               finish_component(r);
               hit = 1'b1;
            end
         end
         PH_LEN_HI: begin
            glyph_held = b;
            glyph_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            glyph_left = {glyph_held, b};
            hit = 1'b1;
            r.kind = KIND_LENGTH;
            r.instr_length = glyph_left;
            if (glyph_left == 16'h0000) begin
               glyph_phase = PH_DONE;
               r.last = 1'b1;
            end else begin
               glyph_phase = PH_INSTR;
            end
         end
         PH_INSTR: begin
            glyph_left = glyph_left - 16'd1;
            hit = 1'b1;
            r.kind = KIND_INSTR;
            r.instr_byte = b;
            if (glyph_left == 16'h0000) begin
               glyph_phase = PH_DONE;
               r.last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      errors++;
      if (errors <= 100) begin
         $display("%0t mismatch %s: want %h got %h", $realtime, what, want, got);
      end
   endtask

   task automatic compare_result(input rsp_word_type want, input rsp_word_type got);
      if (want.kind !== got.kind) report_mismatch("kind", 16'(want.kind), 16'(got.kind));
      if (want.comp_flags !== got.comp_flags)
         report_mismatch("comp_flags", want.comp_flags, got.comp_flags);
      if (want.child_glyph !== got.child_glyph)
         report_mismatch("child_glyph", want.child_glyph, got.child_glyph);
      if (want.arg_one !== got.arg_one) report_mismatch("arg_one", want.arg_one, got.arg_one);
      if (want.arg_two !== got.arg_two) report_mismatch("arg_two", want.arg_two, got.arg_two);
      if (want.scale_xx !== got.scale_xx)
         report_mismatch("scale_xx", want.scale_xx, got.scale_xx);
      if (want.scale_xy !== got.scale_xy)
         report_mismatch("scale_xy", want.scale_xy, got.scale_xy);
      if (want.scale_yx !== got.scale_yx)
         report_mismatch("scale_yx", want.scale_yx, got.scale_yx);
      if (want.scale_yy !== got.scale_yy)
         report_mismatch("scale_yy", want.scale_yy, got.scale_yy);
      if (want.instr_length !== got.instr_length)
         report_mismatch("instr_length", want.instr_length, got.instr_length);
      if (want.instr_byte !== got.instr_byte)
         report_mismatch("instr_byte", 16'(want.instr_byte), 16'(got.instr_byte));
      if (want.last !== got.last) report_mismatch("last", 16'(want.last), 16'(got.last));
   endtask

   function automatic rsp_word_type component_want(
      input logic [15:0] flags, input logic [15:0] index,
      input logic [15:0] a1, input logic [15:0] a2,
      input logic [15:0] xx, input logic [15:0] yy, input logic last);
      rsp_word_type r;
      r = '0;
      r.kind = KIND_COMPONENT;
      r.comp_flags = flags;
      r.child_glyph = index;
      r.arg_one = a1;
      r.arg_two = a2;
      r.scale_xx = xx;
      r.scale_yy = yy;
      r.last = last;
      return r;
   endfunction

   function automatic rsp_word_type length_want(input logic [15:0] len, input logic last);
      rsp_word_type r;
      r = '0;
      r.kind = KIND_LENGTH;
      r.instr_length = len;
      r.last = last;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] d, input logic st, input bit typed,
                          input rsp_word_type want);
      glyph_row_type row;
      row.w.data_byte = d;
      row.w.start_req = st;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // called and returns at a falling edge
   task automatic offer_byte(input req_word_type w, input bit typed,
                             input rsp_word_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      offer_typed = typed;
      offer_want = want;
      req_word <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_glyph(input bit busy);
      logic [7:0]   q [$];
      logic [15:0]  f;
      req_word_type w;
      int           ncomp;
      int           nbytes;
      int           len;
      int           cut;
      ncomp = busy ? 1 : $urandom_range(1, 3);
      f = 16'h0000;
      for (int c = 0; c < ncomp; c++) begin
         f = 16'($urandom);
         f[FlagMore] = (c < ncomp - 1);
         if (busy) f[FlagInstr] = 1'b1;
         q.push_back(f[15:8]);
         q.push_back(f[7:0]);
         q.push_back(8'($urandom));
         q.push_back(8'($urandom));
         nbytes = (f[FlagWords] ? 4 : 2) + xform_len(f);
         repeat (nbytes) q.push_back(8'($urandom));
      end
      if (f[FlagInstr]) begin
         if (busy) len = $urandom_range(40, 64);
         else if ($urandom_range(0, 19) == 0) len = $urandom_range(9, 300);
         else len = $urandom_range(0, 8);
         q.push_back(8'(len >> 8));
         q.push_back(8'(len));
         repeat (len) q.push_back(8'($urandom));
      end
      cut = q.size();
      // broken glyph: the next start abandons it
      if (!busy && $urandom_range(0, 9) == 0) cut = $urandom_range(1, q.size());
      for (int i = 0; i < cut; i++) begin
         w.data_byte = q[i];
         w.start_req = (i == 0);
         offer_byte(w, 1'b0, '0);
         glyph_items++;
      end
      glyphs_sent++;
   endtask

   // receiver
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            stall_left = HoldCycles;
         end
         if (stall_left == 0 && run_left == 0) begin
            stall_left = pick_gap();
            run_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            run_left--;
         end
      end
   end

   // sampling, prediction, checking, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            bytes_taken++;
            parse_glyph_byte(req_word, due_hit, due_word);
            if (due_hit) records_due.push_back(offer_typed ? offer_want : due_word);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            case (rsp_word.kind)
               KIND_COMPONENT: comp_seen++;
               KIND_LENGTH:    length_seen++;
               KIND_INSTR:     instr_seen++;
               default: begin
               end
            endcase
            if (records_due.size() == 0) begin
               report_mismatch("result with none due", 16'h0000, 16'(rsp_word.kind));
            end else begin
               compare_result(records_due.pop_front(), rsp_word);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
               $display("watchdog: no word moved for %0d cycles", StallLimit);
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   // stimulus
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      no_idle = 1'b0;
      hold_receiver = 1'b0;
      offer_typed = 1'b0;
      offer_want = '0;
      errors = 0;
      quiet_cycles = 0;
      glyph_items = 0;
      glyphs_sent = 0;
      bytes_taken = 0;
      results_seen = 0;
      comp_seen = 0;
      length_seen = 0;
      instr_seen = 0;
      clear_glyph_parser();

      // first glyph right after reset, no start: byte args, zero instruction length
      add_row(8'h01, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1,
              component_want(16'h0100, 16'h0000, 16'hFFFF, 16'h0000,
                             F2d14One, F2d14One, 1'b0));
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1, length_want(16'h0000, 1'b1));
      // byte after the end, dropped
      add_row(8'hAA, 1'b0, 1'b0, '0);
      // word args, all transform flags set (scale wins), more components follow
      add_row(8'h01, 1'b1, 1'b0, '0);
      add_row(8'hE9, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'h7F, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'h80, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h80, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1,
              component_want(16'h01E9, 16'hFFFF, 16'h7FFF, 16'h8000,
                             16'h8000, 16'h8000, 1'b0));
      // start in the middle of the glyph above
      add_row(8'h01, 1'b1, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h12, 1'b0, 1'b0, '0);
      add_row(8'h34, 1'b0, 1'b0, '0);
      add_row(8'h80, 1'b0, 1'b0, '0);
      add_row(8'h7F, 1'b0, 1'b1,
              component_want(16'h0100, 16'h1234, 16'hFF80, 16'h007F,
                             F2d14One, F2d14One, 1'b0));
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h01, 1'b0, 1'b1, length_want(16'h0001, 1'b0));
      offer_want = '0;
      offer_want.kind = KIND_INSTR;
      offer_want.instr_byte = 8'hFF;
      offer_want.last = 1'b1;
      add_row(8'hFF, 1'b0, 1'b1, offer_want);
      offer_want = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
      end

      // long receiver hold while bytes keep coming
      no_idle = 1'b1;
      hold_receiver = 1'b1;
      send_random_glyph(1'b1);

      while (glyph_items < GlyphItems) begin
         no_idle = ($urandom_range(0, 5) == 0);
         send_random_glyph(1'b0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               offer_byte({8'($urandom), 1'b0}, 1'b0, '0);
            end
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (records_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d glyphs, %0d bytes taken, %0d results checked",
               glyphs_sent + 3, bytes_taken, results_seen);
      $display("components %0d, lengths %0d, instruction bytes %0d, one long receiver hold",
               comp_seen, length_seen, instr_seen);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cgrp_pkg.sv
rtl/composite_glyph_record_parser.sv
bench/tb.sv
